/* rtl/core/ccbb_pkg.sv */
// ----------------------------------------------------------------------------
// ccbb_pkg
// Shared types, character codes and helper functions of the bracket
// expression bitmap builder.
// ----------------------------------------------------------------------------
package ccbb_pkg;

  // parser position inside the bracket body
  typedef enum logic [2:0] {
    PH_FIRST,
    PH_CARET,
    PH_BODY,
    PH_ESCAPE,
    PH_DASH
  } phase_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WR,
    ST_EMIT,
    ST_ERR
  } state_t;

  // characters with a meaning inside the brackets
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_DASH   = 8'h2D;

  // escape letters and the control codes they stand for
  localparam logic [7:0] ESC_ZERO = 8'h30;
  localparam logic [7:0] ESC_A    = 8'h61;
  localparam logic [7:0] ESC_B    = 8'h62;
  localparam logic [7:0] ESC_F    = 8'h66;
  localparam logic [7:0] ESC_N    = 8'h6E;
  localparam logic [7:0] ESC_R    = 8'h72;
  localparam logic [7:0] ESC_T    = 8'h74;
  localparam logic [7:0] ESC_V    = 8'h76;

  localparam logic [7:0] CODE_NUL = 8'h00;
  localparam logic [7:0] CODE_BEL = 8'h07;
  localparam logic [7:0] CODE_BS  = 8'h08;
  localparam logic [7:0] CODE_FF  = 8'h0C;
  localparam logic [7:0] CODE_LF  = 8'h0A;
  localparam logic [7:0] CODE_CR  = 8'h0D;
  localparam logic [7:0] CODE_HT  = 8'h09;
  localparam logic [7:0] CODE_VT  = 8'h0B;

  // set geometry
  localparam int WORD_W   = 64;
  localparam int NUM_WORDS = 4;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 72;

  // byte that follows a backslash
  function automatic logic [7:0] map_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      ESC_ZERO: r = CODE_NUL;
      ESC_A:    r = CODE_BEL;
      ESC_B:    r = CODE_BS;
      ESC_F:    r = CODE_FF;
      ESC_N:    r = CODE_LF;
      ESC_R:    r = CODE_CR;
      ESC_T:    r = CODE_HT;
      ESC_V:    r = CODE_VT;
      default:  r = c;
    endcase
    return r;
  endfunction

  // membership bits of lo..hi that fall into one 64-character word
  function automatic logic [WORD_W-1:0] range_mask(input logic [1:0] word,
                                                   input logic [7:0] lo,
                                                   input logic [7:0] hi);
    logic [WORD_W-1:0] m;
    logic [7:0]        code;
    for (int i = 0; i < WORD_W; i++) begin
      code = {word, 6'(i)};
      m[i] = (code >= lo) && (code <= hi);
    end
    return m;
  endfunction

endpackage

/* rtl/core/char_class_bitmap_builder.sv */
// ----------------------------------------------------------------------------
// char_class_bitmap_builder
// Builds the 256-bit membership set of a regex bracket expression from its
// body bytes and sends it out as four 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one body byte per transfer, starting after the opening bracket;
//           in_tuser set marks end of text (the byte is then ignored).
//   out_* : on the closing bracket four transfers, word_index 0..3, tlast on
//           word 3; on end of text one transfer with tuser (error) and tlast
//           set and all bits zero.
//   The set lives in a 4 x 64 bit memory with a registered read. A byte that
//   adds members is read-modify-written: it is accepted while its lowest
//   touched word is read, then each word from the lowest to the highest
//   touched one is written back while the next is read, and no byte is
//   taken meanwhile. Bytes that only change the parse position are taken
//   without leaving idle. A closing bracket reads the four words in turn,
//   one per output transfer; an end of text sends the error transfer.
//   Per-word valid bits clear the set on reset, on end of text and as each
//   word leaves, so no clearing pass is needed.
//   When the receiver stalls, the last word is held in the output register
//   and the block keeps taking bytes until the next word must be sent.
//   Reset (rst_n low, synchronous) returns the parser to the start of a
//   class and drops any pending output.
// ----------------------------------------------------------------------------
module char_class_bitmap_builder (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [ccbb_pkg::TDATA_IN_W-1:0]  in_tdata,   // [7:0] char_code
  input  logic                             in_tuser,   // [0] end_of_text
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [ccbb_pkg::TDATA_OUT_W-1:0] out_tdata,  // [1:0] word_index,
                                                       // [65:2] class_bits
  output logic                             out_tlast,  // last
  output logic                             out_tuser   // [0] error
);

  localparam int WW = ccbb_pkg::WORD_W;

  // ---------------------------------------------------------------- state
  ccbb_pkg::state_t st_r, st_nxt;
  ccbb_pkg::phase_t ph_r, ph_nxt;
  logic        prev_v_r, prev_v_nxt;
  logic [7:0]  prev_m_r, prev_m_nxt;
  logic        low_v_r, low_v_nxt;
  logic [7:0]  low_m_r, low_m_nxt;
  logic        inv_r, inv_nxt;

  // registered member operation of the current byte
  logic        a_en_r, a_en_nxt;
  logic [7:0]  a_lo_r, a_lo_nxt;
  logic [7:0]  a_hi_r, a_hi_nxt;
  logic        b_en_r, b_en_nxt;
  logic [7:0]  b_ch_r, b_ch_nxt;
  logic        emit_inv_r, emit_inv_nxt;
  logic [1:0]  wcur_r, wcur_nxt;
  logic [1:0]  wend_r, wend_nxt;
  logic [ccbb_pkg::NUM_WORDS-1:0] word_vld_r, word_vld_nxt;

  // output register
  logic          out_vld_r, out_vld_nxt;
  logic [1:0]    out_idx_r, out_idx_nxt;
  logic [WW-1:0] out_bits_r, out_bits_nxt;
  logic          out_last_r, out_last_nxt;
  logic          out_err_r, out_err_nxt;

  // memory
  logic [WW-1:0] mem [ccbb_pkg::NUM_WORDS];
  logic [WW-1:0] rdata_r;
  logic [1:0]    raddr;
  logic          mem_we;
  logic [WW-1:0] wdata;

  // ---------------------------------------------------------------- parser
  logic        in_fire;
  logic [7:0]  c;
  logic        p_err, p_emit, p_body, a_used;
  logic        p_a_en, p_b_en;
  logic [7:0]  p_a_lo, p_a_hi, p_b_ch, lo_t, t_val;
  logic [1:0]  p_ws, p_we;
  logic        need_rmw;

  assign in_fire = in_tvalid && in_tready;
  assign c       = in_tdata[7:0];

  // next parse state and member operation for the offered byte
  always_comb begin
    ph_nxt     = ph_r;
    prev_v_nxt = prev_v_r;
    prev_m_nxt = prev_m_r;
    low_v_nxt  = low_v_r;
    low_m_nxt  = low_m_r;
    inv_nxt    = inv_r;
    p_err      = 1'b0;
    p_emit     = 1'b0;
    p_body     = 1'b0;
    a_used     = 1'b0;
    p_a_en     = 1'b0;
    p_a_lo     = '0;
    p_a_hi     = '0;
    p_b_en     = 1'b0;
    p_b_ch     = '0;
    lo_t       = '0;
    t_val      = '0;
    if (in_tuser) begin
      p_err = 1'b1;
    end else begin
      case (ph_r)
        ccbb_pkg::PH_FIRST: begin
          if (c == ccbb_pkg::CH_CARET) begin
            inv_nxt = 1'b1;
            ph_nxt  = ccbb_pkg::PH_CARET;
          end else begin
            p_body = 1'b1;
          end
        end
        ccbb_pkg::PH_CARET: begin
          // lone caret before the closing bracket is a literal caret
          if (c == ccbb_pkg::CH_RBRACK) begin
            inv_nxt    = 1'b0;
            a_used     = 1'b1;
            p_a_en     = 1'b1;
            p_a_lo     = ccbb_pkg::CH_CARET;
            p_a_hi     = ccbb_pkg::CH_CARET;
            p_emit     = 1'b1;
          end else begin
            p_body = 1'b1;
          end
        end
        ccbb_pkg::PH_ESCAPE: begin
          t_val      = ccbb_pkg::map_escape(c);
          lo_t       = low_v_nxt ? low_m_nxt : t_val;
          a_used     = 1'b1;
          p_a_en     = (lo_t <= t_val);
          p_a_lo     = lo_t;
          p_a_hi     = t_val;
          low_v_nxt  = 1'b0;
          prev_v_nxt = 1'b1;
          prev_m_nxt = t_val;
          ph_nxt     = ccbb_pkg::PH_BODY;
        end
        ccbb_pkg::PH_DASH: begin
          if (prev_v_r && (c != ccbb_pkg::CH_RBRACK)) begin
            // range starts at the previous member
            low_v_nxt = 1'b1;
            low_m_nxt = prev_m_r;
          end else begin
            // literal dash, may close a pending range
            lo_t       = low_v_r ? low_m_r : ccbb_pkg::CH_DASH;
            a_used     = 1'b1;
            p_a_en     = (lo_t <= ccbb_pkg::CH_DASH);
            p_a_lo     = lo_t;
            p_a_hi     = ccbb_pkg::CH_DASH;
            low_v_nxt  = 1'b0;
            prev_v_nxt = 1'b1;
            prev_m_nxt = ccbb_pkg::CH_DASH;
          end
          p_body = 1'b1;
        end
        default: begin
          p_body = 1'b1;
        end
      endcase
      // plain body byte
      if (p_body) begin
        if (c == ccbb_pkg::CH_RBRACK) begin
          p_emit = 1'b1;
        end else if (c == ccbb_pkg::CH_BSLASH) begin
          ph_nxt = ccbb_pkg::PH_ESCAPE;
        end else if (c == ccbb_pkg::CH_DASH) begin
          ph_nxt = ccbb_pkg::PH_DASH;
        end else begin
          if (a_used) begin
            // second member after a literal dash, never a range
            p_b_en = 1'b1;
            p_b_ch = c;
          end else begin
            lo_t   = low_v_nxt ? low_m_nxt : c;
            p_a_en = (lo_t <= c);
            p_a_lo = lo_t;
            p_a_hi = c;
          end
          low_v_nxt  = 1'b0;
          prev_v_nxt = 1'b1;
          prev_m_nxt = c;
          ph_nxt     = ccbb_pkg::PH_BODY;
        end
      end
    end
    // a finished or broken class starts over
    if (p_err || p_emit) begin
      ph_nxt     = ccbb_pkg::PH_FIRST;
      prev_v_nxt = 1'b0;
      prev_m_nxt = '0;
      low_v_nxt  = 1'b0;
      low_m_nxt  = '0;
      inv_nxt    = 1'b0;
    end
    if (p_err) begin
      p_a_en = 1'b0;
      p_b_en = 1'b0;
    end
  end

  // span of words touched by the member operation
  always_comb begin
    if (p_a_en && p_b_en) begin
      p_ws = (p_a_lo[7:6] < p_b_ch[7:6]) ? p_a_lo[7:6] : p_b_ch[7:6];
      p_we = (p_a_hi[7:6] > p_b_ch[7:6]) ? p_a_hi[7:6] : p_b_ch[7:6];
    end else if (p_a_en) begin
      p_ws = p_a_lo[7:6];
      p_we = p_a_hi[7:6];
    end else begin
      p_ws = p_b_ch[7:6];
      p_we = p_b_ch[7:6];
    end
  end

  assign need_rmw = (p_a_en || p_b_en) && !p_emit && !p_err;

  // ---------------------------------------------------------------- datapath
  logic          out_free;
  logic [WW-1:0] word_old, word_mask, word_new;

  assign out_free  = !out_vld_r || out_tready;
  assign word_old  = word_vld_r[wcur_r] ? rdata_r : '0;
  assign word_mask = (a_en_r ? ccbb_pkg::range_mask(wcur_r, a_lo_r, a_hi_r) : '0)
                   | (b_en_r ? ccbb_pkg::range_mask(wcur_r, b_ch_r, b_ch_r) : '0);
  assign word_new  = word_old | word_mask;
  assign wdata     = word_new;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    st_nxt       = st_r;
    a_en_nxt     = a_en_r;
    a_lo_nxt     = a_lo_r;
    a_hi_nxt     = a_hi_r;
    b_en_nxt     = b_en_r;
    b_ch_nxt     = b_ch_r;
    emit_inv_nxt = emit_inv_r;
    wcur_nxt     = wcur_r;
    wend_nxt     = wend_r;
    word_vld_nxt = word_vld_r;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_idx_nxt  = out_idx_r;
    out_bits_nxt = out_bits_r;
    out_last_nxt = out_last_r;
    out_err_nxt  = out_err_r;
    in_tready    = 1'b0;
    mem_we       = 1'b0;
    raddr        = wcur_r;
    case (st_r)
      ccbb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        raddr     = p_emit ? 2'd0 : p_ws;
        if (in_tvalid) begin
          a_en_nxt     = p_a_en;
          a_lo_nxt     = p_a_lo;
          a_hi_nxt     = p_a_hi;
          b_en_nxt     = p_b_en;
          b_ch_nxt     = p_b_ch;
          emit_inv_nxt = inv_r;
          wcur_nxt     = p_emit ? 2'd0 : p_ws;
          wend_nxt     = p_we;
          if (p_err) begin
            word_vld_nxt = '0;
            st_nxt       = ccbb_pkg::ST_ERR;
          end else if (p_emit) begin
            // caret-only class is never inverted
            emit_inv_nxt = (ph_r == ccbb_pkg::PH_CARET && c == ccbb_pkg::CH_RBRACK)
                         ? 1'b0 : inv_r;
            st_nxt       = ccbb_pkg::ST_EMIT;
          end else if (need_rmw) begin
            st_nxt = ccbb_pkg::ST_WR;
          end
        end
      end
      ccbb_pkg::ST_WR: begin
        // write this word back, read the next one
        mem_we               = 1'b1;
        word_vld_nxt[wcur_r] = 1'b1;
        raddr                = wcur_r + 2'd1;
        if (wcur_r == wend_r) begin
          st_nxt = ccbb_pkg::ST_IDLE;
        end else begin
          wcur_nxt = wcur_r + 2'd1;
        end
      end
      ccbb_pkg::ST_EMIT: begin
        // one word per output transfer, the word leaves the set as it goes
        raddr = out_free ? wcur_r + 2'd1 : wcur_r;
        if (out_free) begin
          out_vld_nxt          = 1'b1;
          out_idx_nxt          = wcur_r;
          out_bits_nxt         = word_new ^ {WW{emit_inv_r}};
          out_last_nxt         = (wcur_r == 2'(ccbb_pkg::NUM_WORDS - 1));
          out_err_nxt          = 1'b0;
          word_vld_nxt[wcur_r] = 1'b0;
          if (wcur_r == 2'(ccbb_pkg::NUM_WORDS - 1)) begin
            st_nxt = ccbb_pkg::ST_IDLE;
          end else begin
            wcur_nxt = wcur_r + 2'd1;
          end
        end
      end
      ccbb_pkg::ST_ERR: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_idx_nxt  = '0;
          out_bits_nxt = '0;
          out_last_nxt = 1'b1;
          out_err_nxt  = 1'b1;
          st_nxt       = ccbb_pkg::ST_IDLE;
        end
      end
      default: begin
        st_nxt = ccbb_pkg::ST_IDLE;
      end
    endcase
  end

  // control and payload registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ccbb_pkg::ST_IDLE;
      ph_r       <= ccbb_pkg::PH_FIRST;
      prev_v_r   <= 1'b0;
      prev_m_r   <= '0;
      low_v_r    <= 1'b0;
      low_m_r    <= '0;
      inv_r      <= 1'b0;
      word_vld_r <= '0;
      out_vld_r  <= 1'b0;
      wcur_r     <= '0;
    end else begin
      st_r       <= st_nxt;
      word_vld_r <= word_vld_nxt;
      out_vld_r  <= out_vld_nxt;
      wcur_r     <= wcur_nxt;
      if (in_fire) begin
        ph_r     <= ph_nxt;
        prev_v_r <= prev_v_nxt;
        prev_m_r <= prev_m_nxt;
        low_v_r  <= low_v_nxt;
        low_m_r  <= low_m_nxt;
        inv_r    <= inv_nxt;
      end
    end
    a_en_r     <= a_en_nxt;
    a_lo_r     <= a_lo_nxt;
    a_hi_r     <= a_hi_nxt;
    b_en_r     <= b_en_nxt;
    b_ch_r     <= b_ch_nxt;
    emit_inv_r <= emit_inv_nxt;
    wend_r     <= wend_nxt;
    out_idx_r  <= out_idx_nxt;
    out_bits_r <= out_bits_nxt;
    out_last_r <= out_last_nxt;
    out_err_r  <= out_err_nxt;
  end

  // set memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wcur_r] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // ---------------------------------------------------------------- ports
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(ccbb_pkg::TDATA_OUT_W - WW - 2){1'b0}}, out_bits_r, out_idx_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

  // ---------------------------------------------------------------- checks
  // an error result is always the only and last one, with no members
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && (out_tdata == '0))
    else $error("error result without last or with members");

  // the set is empty once its last word has been sent
  a_set_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ccbb_pkg::ST_EMIT) && out_free && (wcur_r == 2'(ccbb_pkg::NUM_WORDS - 1))
    |=> (word_vld_r == '0))
    else $error("set not cleared after emit");

  // end of text always leads to the error result state
  a_eot_err: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser |=> (st_r == ccbb_pkg::ST_ERR))
    else $error("end of text did not raise error result");

  // emitted words come out in index order
  a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ccbb_pkg::ST_EMIT) && out_free |=> (out_tdata[1:0] == $past(wcur_r)))
    else $error("emitted word index out of order");

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bracket expression bitmap builder: bracket
// bodies go in one byte per transfer, a behavioral parser predicts the set
// words and the end-of-text errors, and every result transfer is checked
// field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module tb;

  // one input transfer
  typedef struct packed {
    logic [7:0] code;
    logic       eot;
  } body_byte_t;

  // one result transfer
  typedef struct packed {
    logic [1:0]  index;
    logic [63:0] bits;
    logic        last;
    logic        err_flag;
  } set_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                             in_tvalid = 1'b0;
  logic                             in_tready;
  logic [ccbb_pkg::TDATA_IN_W-1:0]  in_tdata = '0;
  logic                             in_tuser = 1'b0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [ccbb_pkg::TDATA_OUT_W-1:0] out_tdata;
  logic                             out_tlast;
  logic                             out_tuser;

  char_class_bitmap_builder u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #6 clk = ~clk;

  // stimulus and prediction stores
  body_byte_t body_bytes[$];
  set_word_t  expected_words[$];

  // parser state of the prediction
  logic [63:0]      member_words [4];
  ccbb_pkg::phase_t parse_pos;
  logic             prev_ok;
  logic [7:0]       prev_char;
  logic             range_open;
  logic [7:0]       range_lo;
  logic             invert;

  // run bookkeeping
  int n_queued = 0;
  int n_accepted = 0;
  int n_classes = 0;
  int n_inverted = 0;
  int n_unterminated = 0;
  int n_checked = 0;
  int n_mismatch = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  // ---------------------------------------------------------------- predictor

  function automatic void reset_parser();
    for (int k = 0; k < 4; k++) member_words[k] = '0;
    parse_pos  = ccbb_pkg::PH_FIRST;
    prev_ok    = 1'b0;
    prev_char  = '0;
    range_open = 1'b0;
    range_lo   = '0;
    invert     = 1'b0;
  endfunction

  function automatic logic [7:0] escape_code(input logic [7:0] c);
    case (c)
      ccbb_pkg::ESC_ZERO: return ccbb_pkg::CODE_NUL;
      ccbb_pkg::ESC_A:    return ccbb_pkg::CODE_BEL;
      ccbb_pkg::ESC_B:    return ccbb_pkg::CODE_BS;
      ccbb_pkg::ESC_F:    return ccbb_pkg::CODE_FF;
      ccbb_pkg::ESC_N:    return ccbb_pkg::CODE_LF;
      ccbb_pkg::ESC_R:    return ccbb_pkg::CODE_CR;
      ccbb_pkg::ESC_T:    return ccbb_pkg::CODE_HT;
      ccbb_pkg::ESC_V:    return ccbb_pkg::CODE_VT;
      default:            return c;
    endcase
  endfunction

  // add one member, or the open range up to it; a reversed range adds nothing
  function automatic void add_members(input logic [7:0] hi);
    int lo;
    lo = range_open ? int'(range_lo) : int'(hi);
    for (int i = lo; i <= int'(hi); i++) member_words[i / 64][i % 64] = 1'b1;
    range_open = 1'b0;
    range_lo   = '0;
    prev_ok    = 1'b1;
    prev_char  = hi;
  endfunction

  // closing bracket: four words, then back to the start of a class
  function automatic void close_class();
    set_word_t w;
    for (int k = 0; k < 4; k++) begin
      w.index    = 2'(k);
      w.bits     = member_words[k] ^ {64{invert}};
      w.last     = (k == 3);
      w.err_flag = 1'b0;
      expected_words.push_back(w);
    end
    n_classes++;
    if (invert) n_inverted++;
    reset_parser();
  endfunction

  function automatic void body_char(input logic [7:0] c);
    if (c == ccbb_pkg::CH_RBRACK) close_class();
    else if (c == ccbb_pkg::CH_BSLASH) parse_pos = ccbb_pkg::PH_ESCAPE;
    else if (c == ccbb_pkg::CH_DASH) parse_pos = ccbb_pkg::PH_DASH;
    else begin
      add_members(c);
      parse_pos = ccbb_pkg::PH_BODY;
    end
  endfunction

  function automatic void predict_byte(input logic [7:0] c, input logic eot);
    set_word_t w;
    if (eot) begin
      w = '{index: 2'd0, bits: 64'd0, last: 1'b1, err_flag: 1'b1};
      expected_words.push_back(w);
      n_unterminated++;
      reset_parser();
      return;
    end
    case (parse_pos)
      ccbb_pkg::PH_FIRST: begin
        if (c == ccbb_pkg::CH_CARET) begin
          invert    = 1'b1;
          parse_pos = ccbb_pkg::PH_CARET;
        end else begin
          body_char(c);
        end
      end
      // a caret right before the closing bracket is the caret itself
      ccbb_pkg::PH_CARET: begin
        if (c == ccbb_pkg::CH_RBRACK) begin
          invert = 1'b0;
          add_members(ccbb_pkg::CH_CARET);
          close_class();
        end else begin
          body_char(c);
        end
      end
      ccbb_pkg::PH_ESCAPE: begin
        add_members(escape_code(c));
        parse_pos = ccbb_pkg::PH_BODY;
      end
      // dash with a member before it opens a range, else it is literal
      ccbb_pkg::PH_DASH: begin
        if (prev_ok && c != ccbb_pkg::CH_RBRACK) begin
          range_open = 1'b1;
          range_lo   = prev_char;
        end else begin
          add_members(ccbb_pkg::CH_DASH);
        end
        body_char(c);
      end
      default: body_char(c);
    endcase
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(input logic [7:0] c, input logic eot);
    body_bytes.push_back('{code: c, eot: eot});
    n_queued++;
  endtask

  function automatic logic [7:0] plain_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255));
    while (c == ccbb_pkg::CH_RBRACK || c == ccbb_pkg::CH_BSLASH || c == ccbb_pkg::CH_DASH);
    return c;
  endfunction

  function automatic logic [7:0] escape_letter();
    logic [7:0] letters [8];
    letters = '{ccbb_pkg::ESC_ZERO, ccbb_pkg::ESC_A, ccbb_pkg::ESC_B, ccbb_pkg::ESC_F,
                ccbb_pkg::ESC_N, ccbb_pkg::ESC_R, ccbb_pkg::ESC_T, ccbb_pkg::ESC_V};
    if ($urandom_range(99) < 75) return letters[$urandom_range(7)];
    return 8'($urandom_range(255));
  endfunction

  // well-formed class with random content, mostly closed, sometimes cut off
  task automatic random_class();
    int n_elem;
    int pick;
    logic [7:0] a;
    logic [7:0] b;
    if ($urandom_range(99) < 30) add_byte(ccbb_pkg::CH_CARET, 1'b0);
    n_elem = $urandom_range(6);
    for (int e = 0; e < n_elem; e++) begin
      pick = $urandom_range(9);
      case (pick)
        0, 1, 2: add_byte(plain_char(), 1'b0);
        3, 4: begin
          add_byte(ccbb_pkg::CH_BSLASH, 1'b0);
          add_byte(escape_letter(), 1'b0);
        end
        5, 6, 7: begin
          a = plain_char();
          b = plain_char();
          if (a > b && $urandom_range(99) < 80) {a, b} = {b, a};
          add_byte(a, 1'b0);
          add_byte(ccbb_pkg::CH_DASH, 1'b0);
          add_byte(b, 1'b0);
        end
        8: add_byte(ccbb_pkg::CH_DASH, 1'b0);
        default: add_byte(ccbb_pkg::CH_CARET, 1'b0);
      endcase
    end
    if ($urandom_range(99) < 88) add_byte(ccbb_pkg::CH_RBRACK, 1'b0);
    else add_byte(8'($urandom_range(255)), 1'b1);
  endtask

  // random bytes with the odd end of text
  task automatic random_noise();
    int n;
    n = $urandom_range(1, 4);
    for (int i = 0; i < n; i++)
      add_byte(8'($urandom_range(255)), ($urandom_range(99) < 10));
  endtask

  // ---------------------------------------------------------------- idling

  function automatic logic idle_roll();
    logic calm;
    calm = (n_accepted >= 110) && (n_accepted < 170);
    return !calm && ($urandom_range(99) < 31);
  endfunction

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    body_byte_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_byte(in_tdata, in_tuser);
        n_accepted <= n_accepted + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (body_bytes.size() != 0 && !idle_roll()) begin
          nxt = body_bytes.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= nxt.code;
          in_tuser  <= nxt.eot;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- receiver hold-off

  // one long stall of the result side while bytes keep coming
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_accepted >= 40) begin
      hold_left <= 150;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    set_word_t want;
    set_word_t got;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.index    = out_tdata[1:0];
        got.bits     = out_tdata[65:2];
        got.last     = out_tlast;
        got.err_flag = out_tuser;
        n_checked++;
        if (expected_words.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: unexpected transfer index %0d bits %h last %b error %b",
                     $realtime, got.index, got.bits, got.last, got.err_flag);
        end else begin
          want = expected_words.pop_front();
          if (got.index !== want.index || got.bits !== want.bits ||
              got.last !== want.last || got.err_flag !== want.err_flag) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("%0t: mismatch on result %0d", $realtime, n_checked);
              $display("  expected index %0d bits %h last %b error %b",
                       want.index, want.bits, want.last, want.err_flag);
              $display("  actual   index %0d bits %h last %b error %b",
                       got.index, got.bits, got.last, got.err_flag);
            end
          end
        end
      end
      out_tready <= (hold_left == 0) && !idle_roll();
    end
  end

  // ---------------------------------------------------------------- main sequence

  initial begin
    reset_parser();

    // empty class, then a lone caret taken as itself
    add_byte(ccbb_pkg::CH_RBRACK, 1'b0);
    add_byte(ccbb_pkg::CH_CARET, 1'b0);
    add_byte(ccbb_pkg::CH_RBRACK, 1'b0);
    // literal dash at both ends around a reversed range
    add_byte(ccbb_pkg::CH_DASH, 1'b0);
    add_byte("z", 1'b0);
    add_byte(ccbb_pkg::CH_DASH, 1'b0);
    add_byte("a", 1'b0);
    add_byte(ccbb_pkg::CH_DASH, 1'b0);
    add_byte(ccbb_pkg::CH_RBRACK, 1'b0);
    // full range with a doubled dash
    add_byte(8'h00, 1'b0);
    add_byte(ccbb_pkg::CH_DASH, 1'b0);
    add_byte(ccbb_pkg::CH_DASH, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(ccbb_pkg::CH_RBRACK, 1'b0);
    // inverted class with an escape letter and an escaped closing bracket
    add_byte(ccbb_pkg::CH_CARET, 1'b0);
    add_byte(ccbb_pkg::CH_BSLASH, 1'b0);
    add_byte(ccbb_pkg::ESC_V, 1'b0);
    add_byte(ccbb_pkg::CH_BSLASH, 1'b0);
    add_byte(ccbb_pkg::CH_RBRACK, 1'b0);
    add_byte(ccbb_pkg::CH_RBRACK, 1'b0);
    // end of text inside the body, after a backslash, and at the start
    add_byte("a", 1'b0);
    add_byte("b", 1'b0);
    add_byte(8'hFF, 1'b1);
    add_byte(ccbb_pkg::CH_BSLASH, 1'b0);
    add_byte(8'h5A, 1'b1);
    add_byte(8'h00, 1'b1);

    // random part: mostly well-formed classes, some noise
    while (n_queued < 200) begin
      if ($urandom_range(99) < 12) random_noise();
      else random_class();
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted < n_queued) @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (expected_words.size() != 0) n_mismatch++;
    $display("sent %0d body bytes: %0d closed classes (%0d inverted),",
             n_accepted, n_classes, n_inverted);
    $display("  %0d cut off by end of text", n_unterminated);
    $display("checked %0d result transfers, %0d mismatches", n_checked, n_mismatch);
    if (n_mismatch == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #3600000;
    $display("tb failed");
    $finish;
  end

endmodule
